// ===== rtl/pwcm_pkg.sv =====
// package for the perspective warp coordinate map
// constants and types used by the pipeline, including the divider lane state; no dependencies
package pwcm_pkg;

	localparam int COEF_W      = 48;
	localparam int NUM_COEFS   = 8;
	localparam int COORD_BITS_DEF = 11;
	localparam int FRAC_BITS_DEF  = 32;
	localparam int RES_W       = 16;
	localparam int QBITS       = 17;   // quotient bits 16..0
	localparam int ACC_W       = 72;   // wide enough for sums of coef*coord
	localparam int MAG_W       = ACC_W + QBITS + 1;   // holds 2|den| shifted by 16

	localparam logic [2:0] REG_XX   = 3'd0;
	localparam logic [2:0] REG_XY   = 3'd1;
	localparam logic [2:0] REG_XOFF = 3'd2;
	localparam logic [2:0] REG_YX   = 3'd3;
	localparam logic [2:0] REG_YY   = 3'd4;
	localparam logic [2:0] REG_YOFF = 3'd5;
	localparam logic [2:0] REG_PX   = 3'd6;
	localparam logic [2:0] REG_PY   = 3'd7;

	// one step of the divider lane
	typedef struct packed {
		logic [MAG_W-1:0] n;
		logic [QBITS-1:0] q;
		logic             neg;
		logic             sat;
	} div_lane_t;

endpackage

// ===== rtl/pwcm_mac.sv =====
// numerator and divisor evaluation: products then sums, two register stages
// depends on pwcm_pkg
module pwcm_mac #(
	parameter int COORD_BITS = pwcm_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pwcm_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_v,
	input  logic [COORD_BITS-1:0]         x,
	input  logic [COORD_BITS-1:0]         y,
	input  logic signed [pwcm_pkg::COEF_W-1:0] coef [pwcm_pkg::NUM_COEFS],
	output logic                          out_v,
	output logic signed [pwcm_pkg::ACC_W-1:0] nx,
	output logic signed [pwcm_pkg::ACC_W-1:0] ny,
	output logic signed [pwcm_pkg::ACC_W-1:0] den
);
	import pwcm_pkg::*;

	logic signed [ACC_W-1:0] p_s1 [6];
	logic signed [ACC_W-1:0] c_s1 [3];
	logic                    v_s1;
	logic signed [COORD_BITS:0] xs, ys;

	assign xs = {1'b0, x};
	assign ys = {1'b0, y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			out_v <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= ACC_W'(coef[REG_XX] * xs);
			p_s1[1] <= ACC_W'(coef[REG_XY] * ys);
			p_s1[2] <= ACC_W'(coef[REG_YX] * xs);
			p_s1[3] <= ACC_W'(coef[REG_YY] * ys);
			p_s1[4] <= ACC_W'(coef[REG_PX] * xs);
			p_s1[5] <= ACC_W'(coef[REG_PY] * ys);
			c_s1[0] <= ACC_W'(coef[REG_XOFF]);
			c_s1[1] <= ACC_W'(coef[REG_YOFF]);
			c_s1[2] <= ACC_W'(signed'({1'b0, 1'b1, {FRAC_BITS{1'b0}}}));
			nx  <= p_s1[0] + p_s1[1] + c_s1[0];
			ny  <= p_s1[2] + p_s1[3] + c_s1[1];
			den <= p_s1[4] + p_s1[5] + c_s1[2];
		end
	end
endmodule

// ===== rtl/pwcm_div.sv =====
// pipelined restoring divider, one quotient bit per stage, round to nearest, saturate
// depends on pwcm_pkg
module pwcm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_v,
	input  logic signed [pwcm_pkg::ACC_W-1:0] nx,
	input  logic signed [pwcm_pkg::ACC_W-1:0] ny,
	input  logic signed [pwcm_pkg::ACC_W-1:0] den,
	output logic                          out_v,
	output logic signed [pwcm_pkg::RES_W-1:0] qx,
	output logic signed [pwcm_pkg::RES_W-1:0] qy,
	output logic                          fault
);
	import pwcm_pkg::*;

	localparam int NST = QBITS + 1;

	// stage 0 prepares 2|num|+|den| and 2|den|; stages 1..17 resolve bits 16..0
	div_lane_t        lx [NST];
	div_lane_t        ly [NST];
	logic [MAG_W-1:0] d  [NST];
	logic             z  [NST];
	logic             v  [NST];

	logic [MAG_W-1:0] bmag, dd;

	// saturation flag is filled in by the wide compare below
	function automatic div_lane_t prep(input logic signed [ACC_W-1:0] num,
		input logic dneg, input logic [MAG_W-1:0] b);
		div_lane_t r;
		logic [MAG_W-1:0] a;
		a = num[ACC_W-1] ? MAG_W'(-num) : MAG_W'(num);
		r.n   = (a << 1) + b;
		r.q   = '0;
		r.neg = num[ACC_W-1] ^ dneg;
		r.sat = 1'b0;
		return r;
	endfunction

	function automatic div_lane_t step(input div_lane_t l, input logic [MAG_W-1:0] dk,
		input int k);
		div_lane_t r;
		r = l;
		if (l.n >= dk) begin
			r.n = l.n - dk;
			r.q[k] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [RES_W-1:0] fin(input div_lane_t l);
		logic [QBITS-1:0] cap;
		logic [QBITS-1:0] q;
		cap = l.neg ? QBITS'(32768) : QBITS'(32767);
		q = (l.sat || l.q > cap) ? cap : l.q;
		return l.neg ? RES_W'(-q) : RES_W'(q);
	endfunction

	assign bmag = den[ACC_W-1] ? MAG_W'(-den) : MAG_W'(den);
	assign dd   = bmag << 1;

	// saturation test is exact: bmag < 2^72 so d<<17 fits only when checked in wide form
	logic [MAG_W+QBITS-1:0] dwide;
	logic                   satx, saty;
	div_lane_t              px, py;
	assign dwide = {{QBITS{1'b0}}, dd} << QBITS;

	always_comb begin
		px = prep(nx, den[ACC_W-1], bmag);
		py = prep(ny, den[ACC_W-1], bmag);
		satx = {{QBITS{1'b0}}, px.n} >= dwide;
		saty = {{QBITS{1'b0}}, py.n} >= dwide;
		px.sat = satx;
		py.sat = saty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) v[i] <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v[0] <= in_v;
			for (int i = 1; i < NST; i++) v[i] <= v[i-1];
			out_v <= v[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lx[0] <= px;
			ly[0] <= py;
			d[0]  <= dd;
			z[0]  <= (den == '0);
			for (int i = 1; i < NST; i++) begin
				lx[i] <= lx[i-1].sat ? lx[i-1]
					: step(lx[i-1], d[i-1] << (QBITS - i), QBITS - i);
				ly[i] <= ly[i-1].sat ? ly[i-1]
					: step(ly[i-1], d[i-1] << (QBITS - i), QBITS - i);
				d[i]  <= d[i-1];
				z[i]  <= z[i-1];
			end
			qx    <= z[NST-1] ? '0 : fin(lx[NST-1]);
			qy    <= z[NST-1] ? '0 : fin(ly[NST-1]);
			fault <= z[NST-1];
		end
	end
endmodule

// ===== rtl/perspective_warp_coordinate_map.sv =====
// top level of the perspective warp coordinate map
// holds the coefficient registers and APB port; uses pwcm_pkg, pwcm_mac, pwcm_div
//
// usage:
//  - input channel in_valid/in_ready carries one word (out_x, out_y) per output pixel
//  - output channel out_valid/out_ready returns (src_x, src_y, div_fault)
//  - src = homography(out) / perspective term, rounded to nearest (ties away
//    from zero) and saturated to 16-bit signed; a zero divisor raises div_fault
//    and returns zero coordinates
//  - coefficients are written over the APB port at byte address 8*i, 48 bits
//    of pwdata; write only while no word is in flight
//  - throughput: one word per clock while the output is not stalled; 21 register
//    stages: two multiply/add stages, 18 divider stages and the output register
//  - the whole pipeline advances only when the output register is free or being
//    taken, so a stall holds every stage; in_ready follows that condition
//  - reset clears all valid bits and loads the identity transform
module perspective_warp_coordinate_map #(
	parameter int COORD_BITS = pwcm_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pwcm_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [5:0]                     paddr,
	input  logic [63:0]                    pwdata,
	output logic [63:0]                    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [COORD_BITS-1:0]          out_x,
	input  logic [COORD_BITS-1:0]          out_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [pwcm_pkg::RES_W-1:0] src_x,
	output logic signed [pwcm_pkg::RES_W-1:0] src_y,
	output logic                           div_fault
);
	import pwcm_pkg::*;

	logic signed [COEF_W-1:0] coef_q [NUM_COEFS];
	logic                     en;
	logic                     mac_v, div_v;
	logic signed [ACC_W-1:0]  nx, ny, den;
	logic [2:0]               widx;

	assign pready = 1'b1;
	assign widx   = paddr[5:3];

	// coefficient registers, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++)
				coef_q[i] <= (i == REG_XX || i == REG_YY) ?
					COEF_W'(64'd1 << FRAC_BITS) : '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			coef_q[widx] <= pwdata[COEF_W-1:0];
		end
	end

	// read back sign-extended coefficient
	assign prdata = 64'(coef_q[widx]);

	// pipeline moves when the output register is empty or being drained
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	pwcm_mac #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mac (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(in_valid && in_ready),
		.x(out_x), .y(out_y), .coef(coef_q),
		.out_v(mac_v), .nx(nx), .ny(ny), .den(den)
	);

	pwcm_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(mac_v),
		.nx(nx), .ny(ny), .den(den),
		.out_v(div_v), .qx(src_x), .qy(src_y), .fault(div_fault)
	);

	assign out_valid = div_v;
endmodule

// ===== rtl/pwcm_checker.sv =====
// port-level checks for the perspective warp coordinate map
// depends on pwcm_pkg; bound to the top level below
module pwcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] src_x,
	input logic [15:0] src_y,
	input logic        div_fault,
	input logic        pready
);
	import pwcm_pkg::*;

	// a fault word carries zero coordinates
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_fault |-> src_x == '0 && src_y == '0)
		else $error("fault word with nonzero coordinates");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(src_x) && $stable(src_y))
		else $error("stalled result changed");

	// input is never refused while the output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind perspective_warp_coordinate_map pwcm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .src_x(src_x), .src_y(src_y),
	.div_fault(div_fault), .pready(pready)
);
